[hdl/gif_lzw_encoder_defines.svh]
// Assertion macros shared by the LZW encoder modules.
`ifndef GIF_LZW_ENCODER_DEFINES_SVH
`define GIF_LZW_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/gle_pkg.sv]
// Types, constants and helper functions of the LZW encoder.
`default_nettype none
package gle_pkg;

  localparam int MAX_CODES = 4096;
  localparam int CODE_W    = $clog2(MAX_CODES);
  localparam int NC_W      = CODE_W + 1;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } sym_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic [3:0] root_bits;
    logic       symbol_error;
  } byte_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [3:0]        width;
    logic              last;
    logic              err;
    logic [3:0]        mcs;
  } code_req_t;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [7:0]        sym;
    logic [CODE_W-1:0] sib;
  } ent_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_FC,
    S_ENT,
    S_START_CLR,
    S_EMIT_PFX,
    S_EMIT_FULL,
    S_EMIT_FINAL,
    S_EMIT_END
  } gle_state_t;

  // Bit length of v, with a length of 1 for zero.
  function automatic logic [3:0] bit_len(input logic [NC_W-1:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < NC_W; i++) begin
      if ((v >> i) != '0) n = 4'(i + 1);
    end
    return n;
  endfunction

  // Palette size clamped to 1..256.
  function automatic logic [8:0] pal_limit(input logic [8:0] ps);
    logic [8:0] n;
    n = ps;
    if (ps == 9'd0) n = 9'd1;
    if (ps > 9'd256) n = 9'd256;
    return n;
  endfunction

  function automatic logic [8:0] clear_code(input logic [8:0] ps);
    logic [8:0] n;
    logic [3:0] bl;
    n  = pal_limit(ps) - 9'd1;
    bl = bit_len(NC_W'(n));
    return 9'd1 << bl;
  endfunction

endpackage
`default_nettype wire

[hdl/gle_packer.sv]
// Bit packer: collects variable-width codes LSB first and hands out bytes.
`default_nettype none
`include "gif_lzw_encoder_defines.svh"
module gle_packer
  import gle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       code_valid,
  input  wire code_req_t  code_req,
  output logic            code_ready,
  output logic            byte_valid,
  input  wire logic       byte_stall,
  output byte_item_t      byte_item
);

  logic [19:0] acc, acc_next;
  logic [4:0]  cnt, cnt_next;
  logic        lastmode, lastmode_next;
  logic        err, err_next;
  logic [3:0]  mcs, mcs_next;
  logic        can_load, load, load_last;
  logic        code_fire;
  logic [CODE_W-1:0] masked;

  assign can_load   = !byte_valid || !byte_stall;
  assign code_ready = (cnt < 5'd8) && !lastmode;
  assign code_fire  = code_valid && code_ready;
  assign masked     = code_req.code & ~({CODE_W{1'b1}} << code_req.width);

  always_comb begin
    acc_next      = acc;
    cnt_next      = cnt;
    lastmode_next = lastmode;
    err_next      = err;
    mcs_next      = mcs;
    load          = 1'b0;
    load_last     = 1'b0;
    if (code_fire) begin
      acc_next      = acc | (20'(masked) << cnt);
      cnt_next      = cnt + 5'(code_req.width);
      lastmode_next = code_req.last;
      err_next      = code_req.err;
      mcs_next      = code_req.mcs;
    end else if (can_load && cnt >= 5'd8) begin
      load      = 1'b1;
      load_last = lastmode && (cnt == 5'd8);
      acc_next  = acc >> 8;
      cnt_next  = cnt - 5'd8;
      if (load_last) lastmode_next = 1'b0;
    end else if (can_load && lastmode && cnt != 5'd0) begin
      // flush the partial final byte
      load          = 1'b1;
      load_last     = 1'b1;
      acc_next      = '0;
      cnt_next      = '0;
      lastmode_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      cnt        <= '0;
      lastmode   <= 1'b0;
      err        <= 1'b0;
      mcs        <= '0;
      byte_valid <= 1'b0;
    end else begin
      acc      <= acc_next;
      cnt      <= cnt_next;
      lastmode <= lastmode_next;
      err      <= err_next;
      mcs      <= mcs_next;
      if (load) begin
        byte_valid <= 1'b1;
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_item.out_byte     <= acc[7:0];
      byte_item.last_byte    <= load_last;
      byte_item.root_bits    <= mcs;
      byte_item.symbol_error <= err;
    end
  end

  `GLE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= 5'd19, "packer bit count overflow")
  `GLE_ASSERT_NEXT(a_last_empties, load && load_last, cnt == 5'd0 && !lastmode,
    "final byte left bits behind")
  `GLE_ASSERT_NEXT(a_code_adds, code_fire, cnt == $past(cnt) + 5'($past(code_req.width)),
    "code width not added to bit count")

endmodule
`default_nettype wire

[hdl/gif_lzw_encoder.sv]
// Reset (synchronous) clears control state, then a pass over all 4096 entries zeroes the
// first-child memory while the symbol input stalls. Per symbol: the transfer, a first-child
// read and a probe of each child entry in the chain, then each emitted code in turn (prefix
// on a miss, clear when full, final and end on the last symbol); a stream's first symbol
// skips the lookup and emits the clear code. A code waits while the packer holds 8 or more
// bits or is flushing the final byte; it hands out one byte per cycle while byte_stall is low.
`default_nettype none
`include "gif_lzw_encoder_defines.svh"
module gif_lzw_encoder
  import gle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [8:0] cfg_data,
  input  wire logic       sym_valid,
  output logic            sym_stall,
  input  wire sym_item_t  sym_item,
  output logic            byte_valid,
  input  wire logic       byte_stall,
  output byte_item_t      byte_item
);

  logic [CODE_W-1:0] fc_mem [MAX_CODES];
  ent_t              ent_mem [MAX_CODES];
  logic [CODE_W-1:0] fc_q;
  ent_t              ent_q;
  logic [CODE_W-1:0] ent_rd_addr;

  gle_state_t        state, state_next;
  logic [CODE_W-1:0] init_addr;
  logic [8:0]        palette_size;
  logic [8:0]        clear;
  logic [NC_W-1:0]   next_code;
  logic [3:0]        width;
  logic [CODE_W-1:0] prefix_code;
  logic              prefix_valid;
  logic              err;
  logic [7:0]        sym;
  logic              last;
  logic [CODE_W-1:0] walk;

  logic              sym_fire, code_valid, code_ready, code_fire;
  code_req_t         code_req;
  logic [NC_W-1:0]   first_code;
  logic              fc_ok, match_pfx, hit, sib_ok, full, dict_we;
  logic [8:0]        limit, new_clear;
  logic              bad_sym;

  assign sym_fire   = sym_valid && !sym_stall;
  assign code_fire  = code_valid && code_ready;
  assign first_code = NC_W'(clear) + NC_W'(2);
  assign fc_ok      = ({1'b0, fc_q} >= first_code) && ({1'b0, fc_q} < next_code);
  assign match_pfx  = ent_q.prefix == prefix_code;
  assign hit        = match_pfx && (ent_q.sym == sym);
  assign sib_ok     = match_pfx && ({1'b0, ent_q.sib} >= first_code) && (ent_q.sib < walk);
  assign full       = next_code >= NC_W'(MAX_CODES);
  assign dict_we    = (state == S_EMIT_PFX) && code_fire && !full;
  assign limit      = pal_limit(palette_size);
  assign new_clear  = clear_code(palette_size);
  assign bad_sym    = {1'b0, sym_item.symbol} >= limit;
  assign ent_rd_addr = (state == S_FC) ? fc_q : ent_q.sib;

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (init_addr == {CODE_W{1'b1}}) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (sym_fire) state_next = prefix_valid ? S_FC : S_START_CLR;
      end
      S_FC: state_next = fc_ok ? S_ENT : S_EMIT_PFX;
      S_ENT: begin
        priority if (hit) state_next = last ? S_EMIT_FINAL : S_IDLE;
        else if (sib_ok) state_next = S_ENT;
        else state_next = S_EMIT_PFX;
      end
      S_START_CLR: begin
        if (code_fire) state_next = last ? S_EMIT_FINAL : S_IDLE;
      end
      S_EMIT_PFX: begin
        if (code_fire) begin
          priority if (full) state_next = S_EMIT_FULL;
          else state_next = last ? S_EMIT_FINAL : S_IDLE;
        end
      end
      S_EMIT_FULL: begin
        if (code_fire) state_next = last ? S_EMIT_FINAL : S_IDLE;
      end
      S_EMIT_FINAL: begin
        if (code_fire) state_next = S_EMIT_END;
      end
      S_EMIT_END: begin
        if (code_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    sym_stall     = state != S_IDLE;
    code_valid    = 1'b0;
    code_req.code = prefix_code;
    code_req.width = width;
    code_req.last = 1'b0;
    code_req.err  = err;
    code_req.mcs  = bit_len(NC_W'(clear)) - 4'd1;
    unique case (state)
      S_START_CLR, S_EMIT_FULL: begin
        code_valid    = 1'b1;
        code_req.code = CODE_W'(clear);
      end
      S_EMIT_PFX, S_EMIT_FINAL: code_valid = 1'b1;
      S_EMIT_END: begin
        code_valid    = 1'b1;
        code_req.code = CODE_W'(clear) + CODE_W'(1);
        code_req.last = 1'b1;
      end
      S_INIT, S_IDLE, S_FC, S_ENT: code_valid = 1'b0;
      default: code_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      init_addr    <= '0;
      palette_size <= 9'd256;
      clear        <= 9'd256;
      next_code    <= NC_W'(258);
      width        <= 4'd9;
      prefix_code  <= '0;
      prefix_valid <= 1'b0;
      err          <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) palette_size <= cfg_data;
      if (state == S_INIT) init_addr <= init_addr + CODE_W'(1);
      unique case (state)
        S_IDLE: begin
          if (sym_fire) begin
            if (bad_sym) err <= 1'b1;
            if (!prefix_valid) begin
              // latch the stream's clear code and restart the table
              clear     <= new_clear;
              next_code <= NC_W'(new_clear) + NC_W'(2);
              width     <= bit_len(NC_W'(new_clear));
            end
          end
        end
        S_INIT, S_FC, S_EMIT_FINAL: ;
        S_ENT: begin
          if (hit) prefix_code <= walk;
        end
        S_START_CLR: begin
          if (code_fire) begin
            prefix_code  <= CODE_W'(sym);
            prefix_valid <= 1'b1;
          end
        end
        S_EMIT_PFX: begin
          if (code_fire && !full) begin
            next_code   <= next_code + NC_W'(1);
            if (bit_len(next_code) > width) width <= bit_len(next_code);
            prefix_code <= CODE_W'(sym);
          end
        end
        S_EMIT_FULL: begin
          if (code_fire) begin
            next_code   <= first_code;
            width       <= bit_len(NC_W'(clear));
            prefix_code <= CODE_W'(sym);
          end
        end
        S_EMIT_END: begin
          if (code_fire) begin
            prefix_valid <= 1'b0;
            prefix_code  <= '0;
            err          <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // item payload and chain pointer
  always_ff @(posedge clk) begin
    if (sym_fire) begin
      sym  <= bad_sym ? 8'd0 : sym_item.symbol;
      last <= sym_item.last_symbol;
    end
    if (state == S_FC) walk <= fc_q;
    else if (state == S_ENT && !hit && sib_ok) walk <= ent_q.sib;
  end

  // dictionary memories: read every cycle, zero first-child links after reset,
  // write on a new entry
  always_ff @(posedge clk) begin
    fc_q  <= fc_mem[prefix_code];
    ent_q <= ent_mem[ent_rd_addr];
    if (state == S_INIT) begin
      fc_mem[init_addr] <= '0;
    end else if (dict_we) begin
      fc_mem[prefix_code]               <= next_code[CODE_W-1:0];
      ent_mem[next_code[CODE_W-1:0]]    <= '{prefix: prefix_code, sym: sym, sib: fc_q};
    end
  end

  gle_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_req   (code_req),
    .code_ready (code_ready),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item)
  );

  `GLE_ASSERT_NEXT(a_accept_busy, sym_fire, state != S_IDLE, "item accepted but FSM idle")
  `GLE_ASSERT_NOW(a_walk_down, state == S_ENT && $past(state) == S_ENT,
    walk < $past(walk), "sibling chain not descending")
  `GLE_ASSERT_NOW(a_write_room, dict_we, next_code < NC_W'(MAX_CODES),
    "dictionary write past the last code")

endmodule
`default_nettype wire
